@@ sv/mbrc_pkg.sv @@
// Package for the Modbus RTU response checker.
// Holds field widths, frame constants, result codes, the result type and the CRC step.
// Depends on nothing.
package mbrc_pkg;

	localparam int BYTE_W = 8;
	localparam int WORD_W = 16;
	localparam int IDX_W = 7;
	localparam int STAT_W = 2;

	localparam int RX_BUFFER_BYTES_DEF = 256;

	// Wide enough for a frame position plus the CRC field offsets.
	localparam int POS_CMP_W = 10;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW = $clog2(OQ_DEPTH);
	localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

	localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;
	localparam int EXC_BIT_POS = 7;

	localparam logic [POS_CMP_W-1:0] POS_FUNC = 10'd1;
	localparam logic [POS_CMP_W-1:0] POS_LEN = 10'd2;
	localparam logic [POS_CMP_W-1:0] POS_DATA = 10'd3;
	localparam logic [POS_CMP_W-1:0] WR_CRC_END = 10'd6;
	localparam logic [POS_CMP_W-1:0] WR_FRAME_LEN = 10'd8;
	localparam logic [POS_CMP_W-1:0] RD_MIN_LEN = 10'd3;
	localparam logic [POS_CMP_W-1:0] RD_OVERHEAD = 10'd5;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic KIND_WORD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_LEN = 2'd1;
	localparam logic [STAT_W-1:0] ST_EXCEPTION = 2'd2;
	localparam logic [STAT_W-1:0] ST_CRC_ERR = 2'd3;

	typedef struct packed {
		logic              kind;
		logic [WORD_W-1:0] word;
		logic [IDX_W-1:0]  idx;
		logic [STAT_W-1:0] status;
		logic              last;
	} result_t;

	// One byte of the reflected CRC-16, bit by bit.
	function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] c;
		c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ sv/modbus_rtu_response_checker.sv @@
// Top level of the Modbus RTU response checker.
// Uses mbrc_pkg for constants, the result type and the CRC step.
//
// Usage: the input channel carries one received response byte per request, with
// last_byte on the final byte of the frame and frame_kind (read response or write
// acknowledge). The output channel carries results: a register word for each
// completed data byte pair of a read response, and one status result, with last
// set, at the end of every frame. When one byte yields both, the word comes first.
// With the queue empty, the first result of a byte is offered in the cycle after
// the byte is taken, and a second one follows it. The block takes one byte per
// cycle while in_stall is low; the running CRC advances a whole byte in the
// cycle the byte is taken. Results pass through a four-entry output queue, and
// in_stall rises once fewer than two entries are free, so a stalled receiver
// holds the input back after at most a few bytes. The queue drains at one result
// per cycle while out_stall is low. Reset empties the queue and clears the frame
// state; no pass over storage is needed.
module modbus_rtu_response_checker #(
	parameter int RX_BUFFER_BYTES = mbrc_pkg::RX_BUFFER_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mbrc_pkg::BYTE_W-1:0]  rx_byte,
	input  logic                         last_byte,
	input  logic                         frame_kind,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         result_kind,
	output logic [mbrc_pkg::WORD_W-1:0]  reg_word,
	output logic [mbrc_pkg::IDX_W-1:0]   word_index,
	output logic [mbrc_pkg::STAT_W-1:0]  frame_status,
	output logic                         last
);
	import mbrc_pkg::*;

	localparam int PW = $clog2(RX_BUFFER_BYTES + 1);

	logic [PW-1:0]     pos_q;
	logic [WORD_W-1:0] crc_q;
	logic [BYTE_W-1:0] dlen_q;
	logic [BYTE_W-1:0] high_q;
	logic              exc_q;
	logic [WORD_W-1:0] rcrc_q;

	logic [PW-1:0]        pos_d;
	logic [WORD_W-1:0]    crc_d;
	logic [BYTE_W-1:0]    dlen_d;
	logic [BYTE_W-1:0]    high_d;
	logic                 exc_d;
	logic [WORD_W-1:0]    rcrc_d;
	logic                 accept;
	logic                 in_buf;
	logic [POS_CMP_W-1:0] pos_x;
	logic [POS_CMP_W-1:0] crc_end;
	logic [POS_CMP_W-1:0] data_off;
	logic [POS_CMP_W-1:0] count;
	logic                 bad_len;
	logic                 push_word;
	logic                 push_stat;
	logic [STAT_W-1:0]    status;
	result_t              word_r;
	result_t              stat_r;

	result_t           oq_mem [OQ_DEPTH];
	logic [OQ_AW-1:0]  wr_ptr_q;
	logic [OQ_AW-1:0]  rd_ptr_q;
	logic [OQ_CW-1:0]  count_q;
	logic [OQ_AW-1:0]  wr_ptr2;
	logic              pop;
	result_t           head;

	assign accept = in_valid && !in_stall;
	assign in_buf = pos_q < PW'(RX_BUFFER_BYTES);
	assign pos_x = POS_CMP_W'(pos_q);
	assign data_off = pos_x - POS_DATA;

	always_comb begin
		pos_d = pos_q;
		crc_d = crc_q;
		dlen_d = dlen_q;
		high_d = high_q;
		exc_d = exc_q;
		rcrc_d = rcrc_q;
		push_word = 1'b0;
		crc_end = WR_CRC_END;
		if (in_buf) begin
			if (pos_x == POS_FUNC) begin
				exc_d = rx_byte[EXC_BIT_POS];
			end
			if (pos_x == POS_LEN) begin
				dlen_d = rx_byte;
			end
			crc_end = (frame_kind == KIND_WRITE) ? WR_CRC_END
				: (POS_DATA + POS_CMP_W'(dlen_d));
			if (pos_x < crc_end) begin
				crc_d = crc_byte(crc_q, rx_byte);
			end else if (pos_x == crc_end) begin
				rcrc_d = {rcrc_q[WORD_W-1:BYTE_W], rx_byte};
			end else if (pos_x == crc_end + 1'b1) begin
				rcrc_d = {rx_byte, rcrc_q[BYTE_W-1:0]};
			end
			if (frame_kind == KIND_READ && pos_x >= POS_DATA && pos_x < crc_end) begin
				if (!data_off[0]) begin
					high_d = rx_byte;
				end else begin
					push_word = 1'b1;
				end
			end
			pos_d = pos_q + PW'(1);
		end
	end

	assign count = POS_CMP_W'(pos_d);

	always_comb begin
		if (frame_kind == KIND_WRITE) begin
			bad_len = count != WR_FRAME_LEN;
		end else begin
			bad_len = (count < RD_MIN_LEN) || (count < RD_OVERHEAD + POS_CMP_W'(dlen_d));
		end
		if (bad_len) begin
			status = ST_BAD_LEN;
		end else if (exc_d) begin
			status = ST_EXCEPTION;
		end else if (rcrc_d != crc_d) begin
			status = ST_CRC_ERR;
		end else begin
			status = ST_OK;
		end
	end

	assign push_stat = last_byte;

	always_comb begin
		word_r.kind = KIND_WORD;
		word_r.word = {high_q, rx_byte};
		word_r.idx = data_off[IDX_W:1];
		word_r.status = ST_OK;
		word_r.last = 1'b0;
		stat_r.kind = KIND_STATUS;
		stat_r.word = '0;
		stat_r.idx = '0;
		stat_r.status = status;
		stat_r.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
			dlen_q <= '0;
			high_q <= '0;
			exc_q <= 1'b0;
			rcrc_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
				dlen_q <= '0;
				high_q <= '0;
				exc_q <= 1'b0;
				rcrc_q <= '0;
			end else begin
				pos_q <= pos_d;
				crc_q <= crc_d;
				dlen_q <= dlen_d;
				high_q <= high_d;
				exc_q <= exc_d;
				rcrc_q <= rcrc_d;
			end
		end
	end

	assign wr_ptr2 = wr_ptr_q + OQ_AW'(push_word);
	assign pop = out_valid && !out_stall;
	assign in_stall = count_q > OQ_CW'(OQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (accept && push_word) begin
			oq_mem[wr_ptr_q] <= word_r;
		end
		if (accept && push_stat) begin
			oq_mem[wr_ptr2] <= stat_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + OQ_AW'(push_word) + OQ_AW'(push_stat);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
			end
			count_q <= count_q + OQ_CW'(accept && push_word) + OQ_CW'(accept && push_stat)
				- OQ_CW'(pop);
		end
	end

	assign head = oq_mem[rd_ptr_q];
	assign out_valid = count_q != '0;
	assign result_kind = head.kind;
	assign reg_word = head.word;
	assign word_index = head.idx;
	assign frame_status = head.status;
	assign last = head.last;

endmodule

@@ sv/mbrc_checker.sv @@
// Port-level assertions for the Modbus RTU response checker, and the bind that attaches them.
// Uses mbrc_pkg for field widths and result codes.
module mbrc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         result_kind,
	input logic [mbrc_pkg::WORD_W-1:0]  reg_word,
	input logic [mbrc_pkg::IDX_W-1:0]   word_index,
	input logic [mbrc_pkg::STAT_W-1:0]  frame_status,
	input logic                         last
);
	import mbrc_pkg::*;

	// Only status results close a frame.
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (result_kind == KIND_STATUS)))
		else $error("last does not match the result kind");

	// Status results carry no word, and word results carry no status.
	a_fields_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((result_kind == KIND_STATUS && reg_word == '0 && word_index == '0)
			|| (result_kind == KIND_WORD && frame_status == ST_OK)))
		else $error("unused fields of a result are not zero");

	// The input side can only be held back while results are waiting.
	a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(reg_word)
			&& $stable(word_index) && $stable(frame_status) && $stable(last))
		else $error("stalled result changed");

endmodule

bind modbus_rtu_response_checker mbrc_checker u_mbrc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_kind  (result_kind),
	.reg_word     (reg_word),
	.word_index   (word_index),
	.frame_status (frame_status),
	.last         (last)
);
